// ===== src/cnchs_pkg.sv =====
// Package for the homing sequencer: beat types, codes, phase enums and defaults.
package cnchs_pkg;

    // Axis count default and fixed field widths
    localparam int unsigned CNCHS_NUM_AXES = 3;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 32;

    // Input opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_STOPPED = 2'd2;
    localparam logic [1:0] OP_DOOR    = 2'd3;

    // Alarm codes
    localparam logic [1:0] ALARM_NONE     = 2'd0;
    localparam logic [1:0] ALARM_APPROACH = 2'd1;
    localparam logic [1:0] ALARM_PULLOFF  = 2'd2;
    localparam logic [1:0] ALARM_DOOR     = 2'd3;

    // Move kinds
    localparam logic [1:0] KIND_SEEK    = 2'd0;
    localparam logic [1:0] KIND_PULLOFF = 2'd1;
    localparam logic [1:0] KIND_LOCATE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MASKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_DIR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCATE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_POS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_POS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_POS_Z  = 3'd6;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd250;
    localparam logic [3:0]  LOCATE_RST   = 4'd1;

    // Sequence-level phases
    typedef enum logic [2:0] {
        TOP_IDLE  = 3'd0,
        TOP_TRIG  = 3'd1,
        TOP_WAIT0 = 3'd2,
        TOP_WAIT1 = 3'd3,
        TOP_WAIT2 = 3'd4
    } t_top_phase;

    // Per-cycle phases
    typedef enum logic [2:0] {
        CP_INIT   = 3'd0,
        CP_GO     = 3'd1,
        CP_WAIT   = 3'd2,
        CP_DELAY  = 3'd3,
        CP_FINISH = 3'd4
    } t_cyc_phase;

    // Input beat
    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] limit_state;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic               homing_active;
        logic [2:0]         axis_lock;
        logic               move_start;
        logic [2:0]         move_positive;
        logic [1:0]         move_kind;
        logic               stop_request;
        logic [1:0]         alarm;
        logic [2:0]         pos_load_mask;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               sync_request;
    } t_out_beat;

endpackage

// ===== src/cnc_homing_sequencer_unit.sv =====
// Homing sequencer top level: event decode, cycle sequencing and result register.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+-------------------
//   in        | input     | i_in_valid / o_in_ready    | i_in_beat (t_in_beat)
//   out       | output    | o_out_valid / i_out_ready  | o_out_beat (t_out_beat)
//   cfg       | input     | i_cfg_wr_en, no wait       | i_cfg_idx, i_cfg_wdata
//
// One beat per cycle while o_in_ready is high: each event updates the sequencer state in
// the cycle it is taken and its result lands in the output register on the same edge.
// The output register frees itself in the cycle it is taken, so a stalled output
// holds one result and blocks input only while i_out_ready stays low.
// Reset clears all state and loads the register defaults; no clearing pass.
module cnc_homing_sequencer_unit
    import cnchs_pkg::*;
#(
    parameter int unsigned NUM_AXES = CNCHS_NUM_AXES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic [2:0] AxisMask = 3'((1 << NUM_AXES) - 1);

    // Configuration registers
    logic [8:0]         r_cycle_masks;
    logic [2:0]         r_home_dir;
    logic [15:0]        r_debounce;
    logic [3:0]         r_locate;
    logic signed [31:0] r_home_pos_x;
    logic signed [31:0] r_home_pos_y;
    logic signed [31:0] r_home_pos_z;

    // Sequencer state
    t_top_phase r_top,     n_top;
    t_cyc_phase r_cphase,  n_cphase;
    logic       r_req,     n_req;
    logic       r_running, n_running;
    logic [2:0] r_active,  n_active;
    logic       r_appr,    n_appr;
    logic [4:0] r_moves,   n_moves;
    logic [2:0] r_lock,    n_lock;
    logic       r_stopped, n_stopped;
    logic [15:0] r_delay,  n_delay;

    // Output register
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    logic       w_accept;
    logic [2:0] w_lim;
    logic [2:0] w_mask0, w_mask1, w_mask2;
    logic [4:0] w_moves_init;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign w_lim        = i_in_beat.limit_state & AxisMask;
    assign w_mask0      = r_cycle_masks[2:0] & AxisMask;
    assign w_mask1      = r_cycle_masks[5:3] & AxisMask;
    assign w_mask2      = r_cycle_masks[8:6] & AxisMask;
    assign w_moves_init = {r_locate, 1'b1};

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_masks <= '0;
            r_home_dir    <= '0;
            r_debounce    <= DEBOUNCE_RST;
            r_locate      <= LOCATE_RST;
            r_home_pos_x  <= '0;
            r_home_pos_y  <= '0;
            r_home_pos_z  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_CYCLE_MASKS: r_cycle_masks <= i_cfg_wdata[8:0];
                CFG_HOME_DIR:    r_home_dir    <= i_cfg_wdata[2:0];
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_wdata[15:0];
                CFG_LOCATE:      r_locate      <= i_cfg_wdata[3:0];
                CFG_HOME_POS_X:  r_home_pos_x  <= i_cfg_wdata;
                CFG_HOME_POS_Y:  r_home_pos_y  <= i_cfg_wdata;
                CFG_HOME_POS_Z:  r_home_pos_z  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state and result for the beat at the input
    always_comb begin
        n_top     = r_top;
        n_cphase  = r_cphase;
        n_req     = r_req;
        n_running = r_running;
        n_active  = r_active;
        n_appr    = r_appr;
        n_moves   = r_moves;
        n_lock    = r_lock;
        n_stopped = r_stopped;
        n_delay   = r_delay;
        n_out     = '0;

        unique case (i_in_beat.opcode)
            OP_START: n_req = 1'b1;
            OP_STOPPED: begin
                if (r_running) n_stopped = 1'b1;
            end
            OP_DOOR: begin
                if (r_running) begin
                    n_out.alarm = ALARM_DOOR;
                    n_running   = 1'b0;
                    n_cphase    = CP_INIT;
                    n_top       = TOP_IDLE;
                    n_req       = 1'b0;
                end
            end
            OP_TICK: begin
                // sequence level: launch cycles in turn, skip empty masks
                unique case (r_top)
                    TOP_IDLE: if (r_req) n_top = TOP_TRIG;
                    TOP_TRIG: begin
                        if (w_mask0 != 3'd0) begin
                            n_active = w_mask0; n_running = 1'b1; n_cphase = CP_INIT;
                        end
                        n_top = TOP_WAIT0;
                    end
                    TOP_WAIT0: begin
                        if (!r_running) begin
                            if (w_mask1 != 3'd0) begin
                                n_active = w_mask1; n_running = 1'b1; n_cphase = CP_INIT;
                            end
                            n_top = TOP_WAIT1;
                        end
                    end
                    TOP_WAIT1: begin
                        if (!r_running) begin
                            if (w_mask2 != 3'd0) begin
                                n_active = w_mask2; n_running = 1'b1; n_cphase = CP_INIT;
                            end
                            n_top = TOP_WAIT2;
                        end
                    end
                    TOP_WAIT2: begin
                        if (!r_running) begin
                            n_out.sync_request = 1'b1;
                            n_req = 1'b0;
                            n_top = TOP_IDLE;
                        end
                    end
                    default: begin
                        n_top = TOP_IDLE;
                        n_req = 1'b0;
                    end
                endcase

                // cycle level: moves, switch watch and debounce
                if (n_running) begin
                    unique case (n_cphase)
                        CP_INIT: begin
                            n_moves  = w_moves_init;
                            n_appr   = 1'b1;
                            n_lock   = 3'd0;
                            n_cphase = CP_GO;
                        end
                        CP_GO: begin
                            n_lock                = n_active;
                            n_stopped             = 1'b0;
                            n_out.move_start      = 1'b1;
                            n_out.move_positive   = (r_home_dir ^ {3{n_appr}}) & n_active;
                            n_out.move_kind       = !n_appr ? KIND_PULLOFF :
                                                    (n_moves == w_moves_init) ? KIND_SEEK :
                                                    KIND_LOCATE;
                            n_out.pos_load_mask   = n_active;
                            n_cphase              = CP_WAIT;
                        end
                        CP_WAIT: begin
                            if (n_appr) n_lock = n_lock & ~w_lim;
                            if (n_appr && n_stopped && n_lock != 3'd0) begin
                                // approach ended without all switches
                                n_out.alarm = ALARM_APPROACH;
                                n_running   = 1'b0;
                                n_cphase    = CP_INIT;
                                n_top       = TOP_IDLE;
                                n_req       = 1'b0;
                            end else if (!n_appr && n_stopped &&
                                         (w_lim & n_active) != 3'd0) begin
                                // switch still closed after pull-off
                                n_stopped   = 1'b0;
                                n_out.alarm = ALARM_PULLOFF;
                                n_running   = 1'b0;
                                n_cphase    = CP_INIT;
                                n_top       = TOP_IDLE;
                                n_req       = 1'b0;
                            end else begin
                                if ((!n_appr && n_stopped) || n_lock == 3'd0) begin
                                    if (!n_appr && n_stopped) n_stopped = 1'b0;
                                    n_out.stop_request = 1'b1;
                                    n_delay            = r_debounce;
                                    n_cphase           = CP_DELAY;
                                end
                            end
                        end
                        CP_DELAY: begin
                            if (n_delay != 16'd0) begin
                                n_delay = 16'(n_delay - 16'd1);
                            end else begin
                                n_appr   = !n_appr;
                                n_cphase = (n_moves == 5'd0) ? CP_FINISH : CP_GO;
                                n_moves  = 5'(n_moves - 5'd1);
                            end
                        end
                        CP_FINISH: begin
                            n_out.pos_load_mask = n_active;
                            if (n_active[0] && r_home_dir[0]) n_out.pos_x = r_home_pos_x;
                            if (n_active[1] && r_home_dir[1]) n_out.pos_y = r_home_pos_y;
                            if (n_active[2] && r_home_dir[2]) n_out.pos_z = r_home_pos_z;
                            n_running = 1'b0;
                            n_cphase  = CP_INIT;
                        end
                        default: begin
                            n_running = 1'b0;
                            n_cphase  = CP_INIT;
                        end
                    endcase
                end
            end
        endcase

        n_out.homing_active = (n_top == TOP_WAIT0) || (n_top == TOP_WAIT1) ||
                              (n_top == TOP_WAIT2);
        n_out.axis_lock     = n_lock;
    end

    // State registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= TOP_IDLE;
            r_cphase  <= CP_INIT;
            r_req     <= 1'b0;
            r_running <= 1'b0;
            r_active  <= '0;
            r_appr    <= 1'b0;
            r_moves   <= '0;
            r_lock    <= '0;
            r_stopped <= 1'b0;
            r_delay   <= '0;
        end else if (w_accept) begin
            r_top     <= n_top;
            r_cphase  <= n_cphase;
            r_req     <= n_req;
            r_running <= n_running;
            r_active  <= n_active;
            r_appr    <= n_appr;
            r_moves   <= n_moves;
            r_lock    <= n_lock;
            r_stopped <= n_stopped;
            r_delay   <= n_delay;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_out <= n_out;
    end

endmodule

// ===== src/cnchs_checker.sv =====
// Port-level checker for the homing sequencer, bound to the top level.
module cnchs_checker
    import cnchs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // empty output register never blocks input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output register");

    // an alarm aborts: no load, no sync, sequence inactive
    a_alarm_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.alarm != ALARM_NONE |->
            !o_out_beat.homing_active && o_out_beat.pos_load_mask == 3'd0 &&
            !o_out_beat.sync_request && !o_out_beat.move_start)
        else $error("alarm beat carries other activity");

    // completion pulse only once the sequence has gone idle
    a_sync_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.sync_request |->
            !o_out_beat.homing_active && o_out_beat.pos_load_mask == 3'd0)
        else $error("sync pulse while sequence active");

    // a move never starts and stops in one beat
    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.move_start |->
            !o_out_beat.stop_request && o_out_beat.alarm == ALARM_NONE)
        else $error("move start together with stop");

endmodule

bind cnc_homing_sequencer_unit cnchs_checker u_cnchs_checker (.*);

// ===== tb/sv/testbench.sv =====
// Testbench for the homing sequencer: event driver, result monitor and sequence predictor.
module testbench;
    import cnchs_pkg::*;

    // Run shape
    localparam int ITEM_TARGET  = 1050;
    localparam int RUN_CAP      = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int WATCHDOG_MAX = 3000;
    localparam int PRINT_MAX    = 100;

    // How a queued homing run is made to end
    localparam int FATE_CLEAN     = 0;
    localparam int FATE_DOOR      = 1;
    localparam int FATE_NO_SWITCH = 2;
    localparam int FATE_STUCK     = 3;

    // Register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [2:0] AX_ALL = 3'((1 << CNCHS_NUM_AXES) - 1);

    // Registers plus sequencer state, one copy for checking, one for planning
    typedef struct packed {
        logic [8:0]       cyc_masks;
        logic [2:0]       dir_mask;
        logic [15:0]      debounce;
        logic [3:0]       locates;
        logic [2:0][31:0] home_pos;
        t_top_phase       top;
        logic             requested;
        logic             running;
        t_cyc_phase       phase;
        logic [2:0]       axes;
        logic             approach;
        logic [4:0]       moves_left;
        logic [2:0]       lock;
        logic             stopped;
        logic [15:0]      delay;
    } t_seq_state;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_beat              in_beat = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    t_seq_state seq_now;
    t_seq_state seq_plan;
    t_in_beat   homing_event_q[$];
    t_out_beat  homing_result_q[$];
    t_out_beat  next_result;
    t_out_beat  oldest_result;

    int n_sent = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_fail = 0;
    int n_moves = 0;
    int n_syncs = 0;
    int n_alarms[4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int next_hold_at = 250;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;
    int idle_cycles = 0;

    cnc_homing_sequencer_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------
    task automatic seq_reset(inout t_seq_state s);
        s = '0;
        s.debounce = DEBOUNCE_RST;
        s.locates  = LOCATE_RST;
        s.top      = TOP_IDLE;
        s.phase    = CP_INIT;
    endtask

    task automatic apply_reg(inout t_seq_state s, input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CYCLE_MASKS: s.cyc_masks = data[8:0];
            CFG_HOME_DIR:    s.dir_mask = data[2:0];
            CFG_DEBOUNCE:    s.debounce = data[15:0];
            CFG_LOCATE:      s.locates = data[3:0];
            CFG_HOME_POS_X:  s.home_pos[0] = data;
            CFG_HOME_POS_Y:  s.home_pos[1] = data;
            CFG_HOME_POS_Z:  s.home_pos[2] = data;
            default: ;
        endcase
    endtask

    task automatic abort_seq(inout t_seq_state s);
        s.running   = 1'b0;
        s.phase     = CP_INIT;
        s.top       = TOP_IDLE;
        s.requested = 1'b0;
    endtask

    task automatic begin_cycle(inout t_seq_state s, input int idx);
        logic [2:0] m;
        m = 3'(s.cyc_masks >> (3 * idx)) & AX_ALL;
        if (m != 3'd0) begin
            s.axes    = m;
            s.running = 1'b1;
            s.phase   = CP_INIT;
        end
    endtask

    // One event in, one result out
    task automatic sequencer_step(inout t_seq_state s, input t_in_beat b, output t_out_beat r);
        logic [2:0] lim;
        logic [4:0] full_moves;
        logic       aborted;
        lim        = b.limit_state & AX_ALL;
        full_moves = {s.locates, 1'b1};
        aborted    = 1'b0;
        r          = '0;
        case (b.opcode)
            OP_START:   s.requested = 1'b1;
            OP_STOPPED: if (s.running) s.stopped = 1'b1;
            OP_DOOR: begin
                if (s.running) begin
                    r.alarm = ALARM_DOOR;
                    abort_seq(s);
                end
            end
            default: begin
                // sequence level: trigger, then each homing cycle mask in turn
                case (s.top)
                    TOP_IDLE: if (s.requested) s.top = TOP_TRIG;
                    TOP_TRIG: begin
                        begin_cycle(s, 0);
                        s.top = TOP_WAIT0;
                    end
                    TOP_WAIT0: if (!s.running) begin
                        begin_cycle(s, 1);
                        s.top = TOP_WAIT1;
                    end
                    TOP_WAIT1: if (!s.running) begin
                        begin_cycle(s, 2);
                        s.top = TOP_WAIT2;
                    end
                    TOP_WAIT2: if (!s.running) begin
                        r.sync_request = 1'b1;
                        s.requested    = 1'b0;
                        s.top          = TOP_IDLE;
                    end
                    default: begin
                        s.top       = TOP_IDLE;
                        s.requested = 1'b0;
                    end
                endcase
                // cycle level
                if (s.running) begin
                    case (s.phase)
                        CP_INIT: begin
                            s.moves_left = full_moves;
                            s.approach   = 1'b1;
                            s.lock       = 3'd0;
                            s.phase      = CP_GO;
                        end
                        CP_GO: begin
                            s.lock          = s.axes;
                            s.stopped       = 1'b0;
                            r.move_start    = 1'b1;
                            r.move_positive = (s.dir_mask ^ {3{s.approach}}) & s.axes;
                            if (!s.approach) r.move_kind = KIND_PULLOFF;
                            else if (s.moves_left == full_moves) r.move_kind = KIND_SEEK;
                            else r.move_kind = KIND_LOCATE;
                            r.pos_load_mask = s.axes;
                            s.phase         = CP_WAIT;
                        end
                        CP_WAIT: begin
                            if (s.approach) s.lock &= ~lim;
                            if (s.approach && s.stopped && s.lock != 3'd0) begin
                                r.alarm = ALARM_APPROACH;
                                abort_seq(s);
                            end else begin
                                if (!s.approach && s.stopped) begin
                                    s.stopped = 1'b0;
                                    if ((lim & s.axes) != 3'd0) begin
                                        r.alarm = ALARM_PULLOFF;
                                        abort_seq(s);
                                        aborted = 1'b1;
                                    end else begin
                                        r.stop_request = 1'b1;
                                        s.delay        = s.debounce;
                                        s.phase        = CP_DELAY;
                                    end
                                end
                                if (!aborted && s.lock == 3'd0) begin
                                    r.stop_request = 1'b1;
                                    s.delay        = s.debounce;
                                    s.phase        = CP_DELAY;
                                end
                            end
                        end
                        CP_DELAY: begin
                            if (s.delay != 16'd0) begin
                                s.delay = s.delay - 16'd1;
                            end else begin
                                s.approach   = !s.approach;
                                s.phase      = (s.moves_left == 5'd0) ? CP_FINISH : CP_GO;
                                s.moves_left = s.moves_left - 5'd1;
                            end
                        end
                        CP_FINISH: begin
                            r.pos_load_mask = s.axes;
                            if (s.axes[0] && s.dir_mask[0]) r.pos_x = s.home_pos[0];
                            if (s.axes[1] && s.dir_mask[1]) r.pos_y = s.home_pos[1];
                            if (s.axes[2] && s.dir_mask[2]) r.pos_z = s.home_pos[2];
                            s.running = 1'b0;
                            s.phase   = CP_INIT;
                        end
                        default: begin
                            s.running = 1'b0;
                            s.phase   = CP_INIT;
                        end
                    endcase
                end
            end
        endcase
        r.homing_active = (s.top == TOP_WAIT0 || s.top == TOP_WAIT1 || s.top == TOP_WAIT2);
        r.axis_lock     = s.lock;
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        n_fail++;
        if (n_fail <= PRINT_MAX) $display("MISMATCH %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h expected 0x%0h",
                                      n_results, name, got, want));
    endtask

    task automatic check_result(input t_out_beat got, input t_out_beat want);
        check_field("homing_active", 32'(got.homing_active), 32'(want.homing_active));
        check_field("axis_lock", 32'(got.axis_lock), 32'(want.axis_lock));
        check_field("move_start", 32'(got.move_start), 32'(want.move_start));
        check_field("move_positive", 32'(got.move_positive), 32'(want.move_positive));
        check_field("move_kind", 32'(got.move_kind), 32'(want.move_kind));
        check_field("stop_request", 32'(got.stop_request), 32'(want.stop_request));
        check_field("alarm", 32'(got.alarm), 32'(want.alarm));
        check_field("pos_load_mask", 32'(got.pos_load_mask), 32'(want.pos_load_mask));
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("pos_z", got.pos_z, want.pos_z);
        check_field("sync_request", 32'(got.sync_request), 32'(want.sync_request));
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of beats with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_beat  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                sequencer_step(seq_now, in_beat, next_result);
                homing_result_q.push_back(next_result);
                n_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (homing_event_q.size() != 0) begin
                    in_beat  <= homing_event_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare results, stall on a pattern, long hold-offs
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (homing_result_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              n_results));
                end else begin
                    oldest_result = homing_result_q.pop_front();
                    check_result(out_beat, oldest_result);
                end
                if (out_beat.move_start) n_moves++;
                if (out_beat.sync_request) n_syncs++;
                n_alarms[out_beat.alarm]++;
            end
            rx_tick++;
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(3);
                rx_mode_left = $urandom_range(20, 80);
            end else begin
                rx_mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (n_results >= next_hold_at) begin
                // long hold: input side must back up behind the full result register
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 500;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(1) == 1);
                    2: out_ready <= ($urandom_range(3) == 0);
                    default: out_ready <= ((rx_tick & 4) != 0);
                endcase
            end
        end
    end

    // Watchdog: no beat on either side for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Timeout: no beat for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus planning
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        apply_reg(seq_now, idx, data);
        apply_reg(seq_plan, idx, data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (homing_event_q.size() != 0 || in_valid || homing_result_q.size() != 0);
    endtask

    // Queue an event and advance the planning copy; returns what it predicts
    task automatic plan_push(input logic [1:0] op, input logic [2:0] lim, output t_out_beat r);
        t_in_beat b;
        b.opcode      = op;
        b.limit_state = lim;
        n_sent++;
        sequencer_step(seq_plan, b, r);
        homing_event_q.push_back(b);
    endtask

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] rand_trip();
        return {$urandom_range(2) == 0, $urandom_range(2) == 0, $urandom_range(2) == 0};
    endfunction

    // Start request followed by events that steer the sequence; a fault is
    // injected once fault_at moves have been started
    task automatic queue_homing_run(input int fate, input int fault_at, input int cap);
        t_out_beat  r;
        logic [1:0] op;
        logic [2:0] lim;
        int         n;
        int         moves_seen;
        bit         armed;
        n          = 0;
        moves_seen = 0;
        plan_push(OP_START, 3'($urandom_range(7)), r);
        while ((seq_plan.requested || seq_plan.running) && n < cap) begin
            op    = OP_TICK;
            lim   = 3'($urandom_range(7));
            armed = (fate != FATE_CLEAN) && moves_seen >= fault_at;
            if (armed && fate == FATE_DOOR && seq_plan.running &&
                $urandom_range(seq_plan.phase == CP_DELAY ? 2 : 7) == 0) begin
                op = OP_DOOR;
            end else if (seq_plan.running && seq_plan.phase == CP_WAIT) begin
                if (seq_plan.approach) begin
                    if (armed && fate == FATE_NO_SWITCH) begin
                        // stop before every switch has tripped
                        if (!seq_plan.stopped) op = OP_STOPPED;
                        else lim = lim & ~seq_plan.lock;
                    end else begin
                        lim = rand_trip();
                    end
                end else if (!seq_plan.stopped) begin
                    if (armed && fate == FATE_STUCK || $urandom_range(2) == 0) op = OP_STOPPED;
                end else if (armed && fate == FATE_STUCK) begin
                    if ((lim & seq_plan.axes) == 3'd0) lim = lim | seq_plan.axes;
                end else begin
                    lim = lim & ~seq_plan.axes;
                end
            end else begin
                // occasional events that the sequencer should shrug off
                case ($urandom_range(19))
                    0: op = OP_START;
                    1: op = OP_STOPPED;
                    default: op = OP_TICK;
                endcase
            end
            plan_push(op, lim, r);
            if (r.move_start) moves_seen++;
            n++;
        end
    endtask

    task automatic queue_idle_noise(input int cnt);
        t_out_beat r;
        int        k;
        for (k = 0; k < cnt; k++) begin
            case ($urandom_range(2))
                0: plan_push(OP_TICK, 3'($urandom_range(7)), r);
                1: plan_push(OP_STOPPED, 3'($urandom_range(7)), r);
                default: plan_push(OP_DOOR, 3'($urandom_range(7)), r);
            endcase
        end
    endtask

    task automatic random_phase();
        int k;
        int fate;
        if ($urandom_range(2) != 0) write_reg(CFG_CYCLE_MASKS, $urandom_range(511));
        if ($urandom_range(2) != 0) write_reg(CFG_HOME_DIR, $urandom_range(7));
        if ($urandom_range(2) != 0) write_reg(CFG_DEBOUNCE, $urandom_range(3));
        if ($urandom_range(2) != 0) write_reg(CFG_LOCATE, $urandom_range(2));
        for (k = 0; k < 3; k++)
            if ($urandom_range(2) == 0) write_reg(CFG_IDX_W'(CFG_HOME_POS_X + k), pick_pos());
        if ($urandom_range(7) == 0) write_reg(CFG_IDX_SPARE, $urandom);
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(9))
                6, 9:    fate = FATE_DOOR;
                7:       fate = FATE_NO_SWITCH;
                8:       fate = FATE_STUCK;
                default: fate = FATE_CLEAN;
            endcase
            queue_homing_run(fate, $urandom_range(1, 6), RUN_CAP);
            queue_idle_noise($urandom_range(0, 3));
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        t_out_beat r;
        seq_reset(seq_now);
        seq_reset(seq_plan);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: no axes in any cycle, so a start runs straight to sync
        plan_push(OP_TICK, 3'd7, r);
        plan_push(OP_TICK, 3'd0, r);
        plan_push(OP_STOPPED, 3'd5, r);
        plan_push(OP_DOOR, 3'd2, r);
        plan_push(OP_START, 3'd7, r);
        plan_push(OP_START, 3'd0, r);
        plan_push(OP_TICK, 3'd7, r);
        plan_push(OP_TICK, 3'd0, r);
        plan_push(OP_STOPPED, 3'd7, r);
        plan_push(OP_TICK, 3'd7, r);
        plan_push(OP_DOOR, 3'd0, r);
        plan_push(OP_TICK, 3'd0, r);
        plan_push(OP_TICK, 3'd7, r);
        plan_push(OP_TICK, 3'd0, r);
        plan_push(OP_DOOR, 3'd7, r);
        wait_drained();

        // One axis per cycle, extreme home positions, every fault once
        write_reg(CFG_CYCLE_MASKS, 9'o421);
        write_reg(CFG_HOME_DIR, 3'b101);
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LOCATE, 4'd0);
        write_reg(CFG_HOME_POS_X, 32'h7FFF_FFFF);
        write_reg(CFG_HOME_POS_Y, 32'h8000_0000);
        write_reg(CFG_HOME_POS_Z, 32'h8000_0000);
        write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
        queue_homing_run(FATE_CLEAN, 1, RUN_CAP);
        queue_homing_run(FATE_NO_SWITCH, 2, RUN_CAP);
        queue_homing_run(FATE_STUCK, 1, RUN_CAP);
        queue_homing_run(FATE_DOOR, 3, RUN_CAP);
        wait_drained();

        // Locate count changed in the middle of a cycle
        write_reg(CFG_CYCLE_MASKS, 9'o007);
        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_LOCATE, 4'd2);
        queue_homing_run(FATE_CLEAN, 1, 14);
        wait_drained();
        write_reg(CFG_LOCATE, 4'd0);
        queue_homing_run(FATE_CLEAN, 1, RUN_CAP);
        wait_drained();

        // Most locate passes, all axes in the last cycle only
        write_reg(CFG_CYCLE_MASKS, 9'o700);
        write_reg(CFG_HOME_DIR, 3'b111);
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LOCATE, 4'd15);
        queue_homing_run(FATE_CLEAN, 1, RUN_CAP);
        wait_drained();

        // Longest debounce; a door event ends the wait
        write_reg(CFG_CYCLE_MASKS, 9'o001);
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        queue_homing_run(FATE_DOOR, 1, RUN_CAP);
        wait_drained();
        write_reg(CFG_DEBOUNCE, 16'd2);
        write_reg(CFG_LOCATE, 4'd1);
        write_reg(CFG_CYCLE_MASKS, 9'o777);

        while (n_sent < ITEM_TARGET) random_phase();

        wait_drained();
        repeat (4) @(posedge clk);
        if (homing_result_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", homing_result_q.size()));
        $display("Run covered %0d event beats and %0d results: %0d moves, %0d full sequences",
                 n_accepted, n_results, n_moves, n_syncs);
        $display("Aborts seen: %0d approach, %0d pull-off, %0d door; %0d mismatches",
                 n_alarms[ALARM_APPROACH], n_alarms[ALARM_PULLOFF], n_alarms[ALARM_DOOR],
                 n_fail);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
